### rtl/timestamp_difference_core_defines.svh
// Assertion macros shared by the timestamp difference RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef TIMESTAMP_DIFFERENCE_CORE_DEFINES_SVH
`define TIMESTAMP_DIFFERENCE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsd: same-cycle check failed");

// Implication with a fixed delay counted from the next edge.
`define TSD_ASSERT_LATER(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##dly (cons)) \
    else $error("tsd: delayed check failed");

`endif

### rtl/tsd_pkg.sv
// Types, constants and the month table for the timestamp difference core.
// No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  // Reciprocals: floor((x * RECIP_100) >> 21) == x / 100 and
  // floor((x * RECIP_400) >> 23) == x / 400 for all x below 43690.
  localparam logic [14:0] RECIP_100  = 15'd20972;
  localparam logic [14:0] RECIP_400  = 15'd20972;
  // floor((r * RECIP_60) >> 18) == r / 60 for r below 4697.
  localparam logic [12:0] RECIP_60   = 13'd4370;
  localparam int          SHIFT_100  = 21;
  localparam int          SHIFT_400  = 23;
  localparam int          SHIFT_60   = 18;
  localparam logic [12:0] SEC_PER_HR = 13'd3600;

  // Days before the month; month 0 reads as January, 13..15 as December.
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      default:    v = 9'd334;
    endcase
    return v;
  endfunction

endpackage

### rtl/tsd_stamp.sv
// Three-stage conversion of one timestamp into absolute hours plus the
// minute/second offset within the hour. Depends on tsd_pkg.
`timescale 1ns / 1ps

module tsd_stamp
  import tsd_pkg::*;
(
  input  logic        clk,
  input  stamp_t      stamp_i,
  output logic [27:0] hours_o,
  output logic [11:0] msec_o
);

  // stage 1: constant products and table lookup
  logic [13:0] y1_r;
  logic [29:0] p99_r, p399_r, p100_r;
  logic [29:0] p99_nxt, p399_nxt, p100_nxt;
  logic [22:0] y365_r, y365_nxt;
  logic [8:0]  dd_r, dd_nxt;
  logic        late1_r;
  logic [4:0]  hh1_r;
  logic [11:0] ms1_r, ms_nxt;

  always_comb begin
    p99_nxt  = 30'(15'(stamp_i.year) + 15'd99) * 30'(RECIP_100);
    p399_nxt = 30'(15'(stamp_i.year) + 15'd399) * 30'(RECIP_400);
    p100_nxt = 30'(stamp_i.year) * 30'(RECIP_100);
    y365_nxt = 23'(stamp_i.year) * 23'd365;
    dd_nxt   = days_before_month(stamp_i.month) + 9'(stamp_i.day);
    ms_nxt   = 12'(stamp_i.minute) * 12'd60 + 12'(stamp_i.second);
  end

  always_ff @(posedge clk) begin
    y1_r    <= stamp_i.year;
    p99_r   <= p99_nxt;
    p399_r  <= p399_nxt;
    p100_r  <= p100_nxt;
    y365_r  <= y365_nxt;
    dd_r    <= dd_nxt;
    late1_r <= (stamp_i.month > 4'd2);
    hh1_r   <= stamp_i.hour;
    ms1_r   <= ms_nxt;
  end

  // stage 2: day count
  logic [8:0]  q99;
  logic [6:0]  q399;
  logic [7:0]  q100;
  logic [12:0] div4;
  logic        leap;
  logic [23:0] days_sum;
  logic [22:0] days2_r;
  logic [4:0]  hh2_r;
  logic [11:0] ms2_r;

  always_comb begin
    q99  = p99_r[SHIFT_100 +: 9];
    q399 = p399_r[SHIFT_400 +: 7];
    q100 = p100_r[SHIFT_100 +: 8];
    div4 = 13'((15'(y1_r) + 15'd3) >> 2);
    // divisible by 400 means divisible by 100 with a quotient divisible by 4
    leap = (y1_r[1:0] == 2'd0) &&
           ((15'(q100) * 15'd100 != 15'(y1_r)) || (q100[1:0] == 2'd0));
    days_sum = 24'(y365_r) + 24'(div4) - 24'(q99) + 24'(q399) + 24'(dd_r)
             + 24'(leap && late1_r);
  end

  always_ff @(posedge clk) begin
    days2_r <= days_sum[22:0];
    hh2_r   <= hh1_r;
    ms2_r   <= ms1_r;
  end

  // stage 3: absolute hours
  logic [27:0] hours3_r;
  logic [11:0] ms3_r;

  always_ff @(posedge clk) begin
    hours3_r <= (28'(days2_r) << 4) + (28'(days2_r) << 3) + 28'(hh2_r);
    ms3_r    <= ms2_r;
  end

  assign hours_o = hours3_r;
  assign msec_o  = ms3_r;

endmodule

### rtl/timestamp_difference_core.sv
// Top level of the timestamp difference core: two stamp converters and the
// subtract / normalize pipeline. Depends on tsd_pkg, tsd_stamp, defines header.
`timescale 1ns / 1ps
`include "timestamp_difference_core_defines.svh"

// Usage
//   Drive both timestamps on the in_ ports and pulse start; the item is taken
//   at that edge. busy is always low, so a new item may enter every cycle.
//   Each item gives one result: out_valid is high for exactly one cycle with
//   out_elapsed_hours, out_elapsed_minutes, out_elapsed_seconds and
//   out_order_error, once the item has passed the register stages.
//   Throughput: one item per cycle. The pipeline has seven register stages
//   (three for date-to-hours conversion, four for subtract, borrow, divide
//   by 60 and output).
//   If the end stamp is earlier, the amounts are zero and out_order_error is
//   set. Hours above 2^27-1 saturate; minutes and seconds stay exact.
//   Reset (rst_n low, synchronous) clears the valid bits, dropping items in
//   flight; the payload registers are not reset.
//   The receiver cannot stall: a result is present for one cycle only.
module timestamp_difference_core
  import tsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [4:0]  in_start_hour,
  input  logic [5:0]  in_start_minute,
  input  logic [5:0]  in_start_second,
  input  logic [13:0] in_end_year,
  input  logic [3:0]  in_end_month,
  input  logic [4:0]  in_end_day,
  input  logic [4:0]  in_end_hour,
  input  logic [5:0]  in_end_minute,
  input  logic [5:0]  in_end_second,
  output logic        out_valid,
  output logic [26:0] out_elapsed_hours,
  output logic [5:0]  out_elapsed_minutes,
  output logic [5:0]  out_elapsed_seconds,
  output logic        out_order_error
);

  localparam int STAGES = 7;

  stamp_t      stamp_a, stamp_b;
  logic [27:0] hours_a, hours_b;
  logic [11:0] ms_a, ms_b;

  assign busy = 1'b0;

  assign stamp_a = '{year: in_start_year, month: in_start_month, day: in_start_day,
                     hour: in_start_hour, minute: in_start_minute,
                     second: in_start_second};
  assign stamp_b = '{year: in_end_year, month: in_end_month, day: in_end_day,
                     hour: in_end_hour, minute: in_end_minute,
                     second: in_end_second};

  tsd_stamp u_stamp_a (.clk(clk), .stamp_i(stamp_a), .hours_o(hours_a), .msec_o(ms_a));
  tsd_stamp u_stamp_b (.clk(clk), .stamp_i(stamp_b), .hours_o(hours_b), .msec_o(ms_b));

  // valid bits travel alongside the payload stages
  logic [STAGES-1:0] vld_r, vld_nxt;

  always_comb begin
    vld_nxt = {vld_r[STAGES-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 4: raw differences
  logic signed [28:0] dh4_r;
  logic signed [12:0] dms4_r;

  always_ff @(posedge clk) begin
    dh4_r  <= $signed({1'b0, hours_b}) - $signed({1'b0, hours_a});
    dms4_r <= $signed({1'b0, ms_b}) - $signed({1'b0, ms_a});
  end

  // stage 5: borrow whole hours so the remainder lands in 0..3599
  logic signed [29:0] hrs5_r, hrs5_nxt;
  logic [11:0]        r5_r, r5_nxt;
  logic signed [13:0] r_wide;
  logic signed [29:0] carry;

  always_comb begin
    if (dms4_r >= $signed({1'b0, SEC_PER_HR})) begin
      r_wide = 14'(dms4_r) - 14'(SEC_PER_HR);
      carry  = 30'sd1;
    end else if (dms4_r >= 13'sd0) begin
      r_wide = 14'(dms4_r);
      carry  = 30'sd0;
    end else if (dms4_r >= -$signed({1'b0, SEC_PER_HR})) begin
      r_wide = 14'(dms4_r) + 14'(SEC_PER_HR);
      carry  = -30'sd1;
    end else begin
      r_wide = 14'(dms4_r) + 14'(SEC_PER_HR) + 14'(SEC_PER_HR);
      carry  = -30'sd2;
    end
    r5_nxt   = r_wide[11:0];
    hrs5_nxt = 30'(dh4_r) + carry;
  end

  always_ff @(posedge clk) begin
    hrs5_r <= hrs5_nxt;
    r5_r   <= r5_nxt;
  end

  // stage 6: reciprocal product for the divide by 60
  logic [24:0]        prod6_r;
  logic [11:0]        r6_r;
  logic signed [29:0] hrs6_r;

  always_ff @(posedge clk) begin
    prod6_r <= 25'(r5_r) * 25'(RECIP_60);
    r6_r    <= r5_r;
    hrs6_r  <= hrs5_r;
  end

  // stage 7: split remainder, clamp hours, flag order
  logic [6:0]  min7;
  logic [11:0] sec7;
  logic        neg7, sat7;
  logic [26:0] hrs_nxt;
  logic [5:0]  min_nxt, sec_nxt;
  logic [26:0] out_hrs_r;
  logic [5:0]  out_min_r, out_sec_r;
  logic        out_err_r;

  always_comb begin
    min7 = prod6_r[SHIFT_60 +: 7];
    sec7 = r6_r - 12'(min7) * 12'd60;
    neg7 = hrs6_r[29];
    sat7 = (hrs6_r[28:27] != 2'd0);
    if (neg7) begin
      hrs_nxt = '0;
      min_nxt = '0;
      sec_nxt = '0;
    end else begin
      hrs_nxt = sat7 ? '1 : hrs6_r[26:0];
      min_nxt = min7[5:0];
      sec_nxt = sec7[5:0];
    end
  end

  always_ff @(posedge clk) begin
    out_hrs_r <= hrs_nxt;
    out_min_r <= min_nxt;
    out_sec_r <= sec_nxt;
    out_err_r <= neg7;
  end

  assign out_valid           = vld_r[STAGES-1];
  assign out_elapsed_hours   = out_hrs_r;
  assign out_elapsed_minutes = out_min_r;
  assign out_elapsed_seconds = out_sec_r;
  assign out_order_error     = out_err_r;

  `TSD_ASSERT_LATER(a_latency, start && !busy, 6, out_valid)
  `TSD_ASSERT_NOW(a_err_zero, out_valid && out_order_error,
    out_elapsed_hours == 27'd0 && out_elapsed_minutes == 6'd0 &&
    out_elapsed_seconds == 6'd0)
  `TSD_ASSERT_NOW(a_rem_range, out_valid,
    out_elapsed_minutes < 6'd60 && out_elapsed_seconds < 6'd60)

endmodule
